/* rtl/page_frame_buffer_writes_macros.svh */
// Assertion macros used by the frame buffer top level.
`ifndef PAGE_FRAME_BUFFER_WRITES_MACROS_SVH
`define PAGE_FRAME_BUFFER_WRITES_MACROS_SVH

// Condition implies consequence in the same cycle.
`define PFB_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the following cycle.
`define PFB_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/pfb_pkg.sv */
// Types and constants of the page-organized frame buffer.
package pfb_pkg;

  localparam logic [2:0] OP_WRITE_BYTE = 3'd0;
  localparam logic [2:0] OP_WRITE_LOW  = 3'd1;
  localparam logic [2:0] OP_WRITE_HIGH = 3'd2;
  localparam logic [2:0] OP_PIXEL      = 3'd3;
  localparam logic [2:0] OP_READ       = 3'd4;

  localparam logic [7:0] BYTE_MASK = 8'hff;
  localparam logic [3:0] PAGE_ROWS = 4'd8;

  // Address width that covers the largest store (16 pages of 256 columns).
  localparam int ADDR_W = 12;

  // Queue between the front decoder and the memory sequencer.
  localparam int QUEUE_DEPTH = 2;

  // One decoded memory command: a read, or a read-modify-write of one page
  // byte with an optional spill into the next page.
  typedef struct packed {
    logic              is_read;
    logic              zero;
    logic              second;
    logic [ADDR_W-1:0] addr0;
    logic [ADDR_W-1:0] addr1;
    logic [7:0]        mask0;
    logic [7:0]        val0;
    logic [7:0]        mask1;
    logic [7:0]        val1;
  } cmd_t;

endpackage

/* rtl/page_frame_buffer_writes.sv */
// Top level of the page-organized monochrome frame buffer.
//
// The store holds PAGES x COLUMNS bytes; each byte is one column of eight
// vertical pixels, bit 0 on top. A transaction is accepted at a rising edge
// where start is high and busy is low. It writes a byte, writes a vertical
// run of bits that may spill into the next page, sets or clears one pixel,
// or reads a byte. Writes return nothing; a read returns read_data_o on a
// single-cycle strobe read_valid_o, which the receiver cannot hold off.
// A decoder turns each transaction into a memory command and drops writes
// that fall outside the store. A two-entry queue feeds a sequencer that
// owns a single-port-write, single-port-read memory with registered reads.
// A read or a one-page write passes the sequencer's idle and first modify
// states, and a write that spills into the next page also its second modify
// state; a new command is taken only in idle. A read result passes the
// queue, the command and read-data registers and the result register. busy
// rises while the queue is full. After reset the sequencer clears the store,
// one byte per cycle, over all PAGES x COLUMNS bytes (1024 at the default
// size); busy stays high for that whole pass and no transaction is taken.
module page_frame_buffer_writes import pfb_pkg::*; #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] operation_i,
  input  logic [6:0] column_i,
  input  logic [5:0] row_i,
  input  logic [2:0] page_index_i,
  input  logic [7:0] data_i,
  input  logic [3:0] bit_count_i,
  output logic       read_valid_o,
  output logic [7:0] read_data_o
);

`include "page_frame_buffer_writes_macros.svh"

  logic accept;
  logic keep;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  logic clearing;
  cmd_t cmd_in;
  cmd_t cmd_head;

  // The queue only fills when the sequencer lags; the clearing pass holds
  // the input off entirely.
  assign busy   = q_full || clearing;
  assign accept = start && !busy;
  assign push   = accept && keep;

  pfb_front #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) u_front (
    .operation_i (operation_i),
    .column_i    (column_i),
    .row_i       (row_i),
    .page_index_i(page_index_i),
    .data_i      (data_i),
    .bit_count_i (bit_count_i),
    .keep_o      (keep),
    .cmd_o       (cmd_in)
  );

  pfb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (cmd_in),
    .pop_i  (pop),
    .data_o (cmd_head),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  pfb_back #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .cmd_i       (cmd_head),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .read_valid_o(read_valid_o),
    .read_data_o (read_data_o)
  );

  `PFB_ASSERT_NOW(a_no_result_in_clear, clearing, !read_valid_o, "result during clear pass")
  `PFB_ASSERT_NOW(a_push_not_full, push, !q_full, "queue overflow")
  `PFB_ASSERT_NOW(a_pop_not_empty, pop, !q_empty && !clearing, "pop from empty queue")
  `PFB_ASSERT_NEXT(a_result_gap, read_valid_o, !read_valid_o, "back-to-back read results")

endmodule

/* rtl/pfb_front.sv */
// Front decoder: turns one transaction into a memory command or drops it.
module pfb_front import pfb_pkg::*; #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic [2:0] operation_i,
  input  logic [6:0] column_i,
  input  logic [5:0] row_i,
  input  logic [2:0] page_index_i,
  input  logic [7:0] data_i,
  input  logic [3:0] bit_count_i,
  output logic       keep_o,
  output cmd_t       cmd_o
);

  logic        col_ok;
  logic        pg_ok;
  logic        rpage_ok;
  logic        next_ok;
  logic [3:0]  n;
  logic [7:0]  nmask;
  logic [7:0]  bits;
  logic [15:0] run_mask;
  logic [15:0] run_val;
  logic [7:0]  pix_mask;
  logic [ADDR_W-1:0] byte_addr;
  logic [ADDR_W-1:0] row_addr;

  assign col_ok   = {2'b00, column_i} < 9'(COLUMNS);
  assign pg_ok    = {2'b00, page_index_i} < 5'(PAGES);
  assign rpage_ok = {2'b00, row_i[5:3]} < 5'(PAGES);
  assign next_ok  = ({2'b00, row_i[5:3]} + 5'd1) < 5'(PAGES);

  assign n     = (bit_count_i > PAGE_ROWS) ? PAGE_ROWS : bit_count_i;
  assign nmask = (n == 4'd0) ? 8'h00 : (BYTE_MASK >> (PAGE_ROWS - n));
  assign bits  = (operation_i == OP_WRITE_HIGH) ? (data_i >> (PAGE_ROWS - n)) : data_i;

  assign run_mask = {8'h00, nmask} << row_i[2:0];
  assign run_val  = ({8'h00, bits} << row_i[2:0]) & run_mask;
  assign pix_mask = 8'h01 << row_i[2:0];

  assign byte_addr = ADDR_W'(int'(page_index_i) * COLUMNS + int'(column_i));
  assign row_addr  = ADDR_W'(int'(row_i[5:3]) * COLUMNS + int'(column_i));

  always_comb begin
    keep_o       = 1'b0;
    cmd_o        = '0;
    cmd_o.addr0  = byte_addr;
    cmd_o.addr1  = row_addr + ADDR_W'(COLUMNS);
    unique case (operation_i) inside
      OP_WRITE_BYTE: begin
        keep_o      = col_ok && pg_ok;
        cmd_o.mask0 = BYTE_MASK;
        cmd_o.val0  = data_i;
      end
      OP_WRITE_LOW, OP_WRITE_HIGH: begin
        keep_o       = col_ok && rpage_ok && (n != 4'd0);
        cmd_o.addr0  = row_addr;
        cmd_o.mask0  = run_mask[7:0];
        cmd_o.val0   = run_val[7:0];
        cmd_o.mask1  = run_mask[15:8];
        cmd_o.val1   = run_val[15:8];
        cmd_o.second = (run_mask[15:8] != 8'h00) && next_ok;
      end
      OP_PIXEL: begin
        keep_o      = col_ok && rpage_ok;
        cmd_o.addr0 = row_addr;
        cmd_o.mask0 = pix_mask;
        cmd_o.val0  = (data_i != 8'h00) ? pix_mask : 8'h00;
      end
      OP_READ: begin
        keep_o        = 1'b1;
        cmd_o.is_read = 1'b1;
        cmd_o.zero    = !(col_ok && pg_ok);
      end
      default: keep_o = 1'b0;
    endcase
  end

endmodule

/* rtl/pfb_queue.sv */
// Short command queue between the front decoder and the memory sequencer.
module pfb_queue import pfb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t data_o,
  output logic full_o,
  output logic empty_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  cmd_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, wr_d;
  logic [PW-1:0] rd_q, rd_d;
  logic [PW:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == (PW+1)'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? PW'(wr_q + 1'b1) : wr_q;
    rd_d  = pop_i  ? PW'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

/* rtl/pfb_back.sv */
// Memory sequencer: clears the store, then runs reads and read-modify-writes.
module pfb_back import pfb_pkg::*; #(
  parameter int COLUMNS = 128,
  parameter int PAGES   = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  output logic       clearing_o,
  output logic       read_valid_o,
  output logic [7:0] read_data_o
);

  localparam int DEPTH = PAGES * COLUMNS;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_MOD0  = 2'd2;
  localparam logic [1:0] S_MOD1  = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  cmd_t          cmd_q;
  logic [7:0]    mem [DEPTH];
  logic [7:0]    rdata_q;
  logic          we;
  logic [AW-1:0] wa;
  logic [7:0]    wd;
  logic [AW-1:0] ra;
  logic          valid_q, valid_d;
  logic [7:0]    rd_out_q, rd_out_d;

  assign pop_o        = (state_q == S_IDLE) && !empty_i;
  assign clearing_o   = state_q == S_CLEAR;
  assign read_valid_o = valid_q;
  assign read_data_o  = rd_out_q;

  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    we       = 1'b0;
    wa       = cmd_q.addr0[AW-1:0];
    wd       = (rdata_q & ~cmd_q.mask0) | cmd_q.val0;
    ra       = cmd_i.addr0[AW-1:0];
    valid_d  = 1'b0;
    rd_out_d = rd_out_q;
    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        wa    = clr_q;
        wd    = 8'h00;
        clr_d = AW'(clr_q + 1'b1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!empty_i) begin
          state_d = S_MOD0;
        end
      end
      S_MOD0: begin
        ra = cmd_q.addr1[AW-1:0];
        if (cmd_q.is_read) begin
          valid_d  = 1'b1;
          rd_out_d = cmd_q.zero ? 8'h00 : rdata_q;
          state_d  = S_IDLE;
        end else begin
          we      = 1'b1;
          state_d = cmd_q.second ? S_MOD1 : S_IDLE;
        end
      end
      S_MOD1: begin
        we      = 1'b1;
        wa      = cmd_q.addr1[AW-1:0];
        wd      = (rdata_q & ~cmd_q.mask1) | cmd_q.val1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_out_q <= rd_out_d;
    if (pop_o) begin
      cmd_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_q <= mem[ra];
  end

endmodule

/* test/tb.sv */
// Self-checking testbench for the page-organized monochrome frame buffer.
module tb import pfb_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLUMNS    = 128;
  localparam int PAGES      = 8;
  localparam int CLK_PERIOD = 10;

  // Operation codes that the block decodes as no operation.
  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  // Cycles to let pass after the last read byte, well above the block's latency.
  localparam int DRAIN_CYCLES = 20;

  // Shadow copy of the frame store. Every accepted transaction is applied to it,
  // and every read queues the byte that the block has to return for it.
  class frame_shadow;
    logic [7:0] image[PAGES][COLUMNS];
    logic [7:0] pending_reads[$];
    int         mismatches;

    function new();
      foreach (image[p, c]) image[p][c] = 8'h00;
      mismatches = 0;
    endfunction

    // Writes a vertical run of n bits starting at a pixel row. Bits that cross
    // the page boundary go to the next page, unless this is the last page.
    function void write_run(int col, int row, logic [7:0] bits, int n);
      int          pg;
      int          offset;
      logic [15:0] run_mask;
      logic [15:0] run_val;
      pg       = row / PAGE_ROWS;
      offset   = row % PAGE_ROWS;
      run_mask = ((16'd1 << n) - 16'd1) << offset;
      run_val  = ({8'h00, bits} << offset) & run_mask;
      if (n == 0 || col >= COLUMNS || pg >= PAGES) return;
      image[pg][col] = (image[pg][col] & ~run_mask[7:0]) | run_val[7:0];
      if (run_mask[15:8] != 8'h00 && pg + 1 < PAGES)
        image[pg+1][col] = (image[pg+1][col] & ~run_mask[15:8]) | run_val[15:8];
    endfunction

    // Applies one accepted transaction to the shadow store.
    function void apply_transaction(logic [2:0] op, logic [6:0] col, logic [5:0] row,
                                    logic [2:0] pg, logic [7:0] data, logic [3:0] count);
      int  n;
      int  pix_page;
      bit  col_ok;
      n        = (count > PAGE_ROWS) ? PAGE_ROWS : count;
      col_ok   = col < COLUMNS;
      pix_page = row / PAGE_ROWS;
      case (op)
        OP_WRITE_BYTE: begin
          if (col_ok && pg < PAGES) image[pg][col] = data;
        end
        OP_WRITE_LOW: begin
          write_run(col, row, data, n);
        end
        OP_WRITE_HIGH: begin
          write_run(col, row, data >> (PAGE_ROWS - n), n);
        end
        OP_PIXEL: begin
          if (col_ok && pix_page < PAGES) begin
            if (data != 8'h00) image[pix_page][col][row % PAGE_ROWS] = 1'b1;
            else image[pix_page][col][row % PAGE_ROWS] = 1'b0;
          end
        end
        OP_READ: begin
          pending_reads.push_back((col_ok && pg < PAGES) ? image[pg][col] : 8'h00);
        end
        default: begin
        end
      endcase
    endfunction

    // Compares one returned byte with the oldest outstanding read.
    function void check_read_byte(logic [7:0] actual);
      logic [7:0] expected;
      if (pending_reads.size() == 0) begin
        $error("read_data: no read outstanding, actual %02h", actual);
        mismatches++;
        return;
      end
      expected = pending_reads.pop_front();
      if (actual !== expected) begin
        $error("read_data: expected %02h, actual %02h", expected, actual);
        mismatches++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [2:0] operation_i = '0;
  logic [6:0] column_i = '0;
  logic [5:0] row_i = '0;
  logic [2:0] page_index_i = '0;
  logic [7:0] data_i = '0;
  logic [3:0] bit_count_i = '0;
  logic       read_valid_o;
  logic [7:0] read_data_o;

  frame_shadow shadow;

  // Hot spot for random addresses, so that reads often land on bytes that
  // were recently drawn into.
  logic [6:0] hot_column;
  logic [2:0] hot_page;

  page_frame_buffer_writes #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .operation_i (operation_i),
    .column_i    (column_i),
    .row_i       (row_i),
    .page_index_i(page_index_i),
    .data_i      (data_i),
    .bit_count_i (bit_count_i),
    .read_valid_o(read_valid_o),
    .read_data_o (read_data_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Results cannot be held off, so every strobe is checked at the edge that
  // ends its cycle. The sampled values are those from before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && read_valid_o) shadow.check_read_byte(read_data_o);
  end

  // Mostly short gaps between transactions, with a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Offers one transaction and holds it until the block takes it. The start
  // line stays high on return, so a following transaction can go out
  // back to back.
  task automatic send_transaction(input logic [2:0] op, input logic [6:0] col,
                                  input logic [5:0] row, input logic [2:0] pg,
                                  input logic [7:0] data, input logic [3:0] count);
    start        <= 1'b1;
    operation_i  <= op;
    column_i     <= col;
    row_i        <= row;
    page_index_i <= pg;
    data_i       <= data;
    bit_count_i  <= count;
    do @(posedge clk_i); while (busy);
    shadow.apply_transaction(op, col, row, pg, data, count);
  endtask

  // Drops start for a number of cycles and puts junk on the payload, which
  // the block must ignore while start is low.
  task automatic idle_cycles(input int cycles);
    if (cycles == 0) return;
    start        <= 1'b0;
    operation_i  <= 3'($urandom);
    column_i     <= 7'($urandom);
    row_i        <= 6'($urandom);
    page_index_i <= 3'($urandom);
    data_i       <= 8'($urandom);
    bit_count_i  <= 4'($urandom);
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic issue(input logic [2:0] op, input logic [6:0] col, input logic [5:0] row,
                       input logic [2:0] pg, input logic [7:0] data, input logic [3:0] count);
    send_transaction(op, col, row, pg, data, count);
    idle_cycles(pick_gap());
  endtask

  // One random transaction. Reads are frequent so that drawing mistakes show
  // up quickly; half the addresses stay near a hot spot that moves now and then.
  task automatic random_transaction(input bit with_gaps);
    logic [2:0] op;
    logic [6:0] col;
    logic [5:0] row;
    logic [2:0] pg;
    logic [3:0] count;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 30) op = OP_READ;
    else if (r < 45) op = OP_WRITE_BYTE;
    else if (r < 60) op = OP_WRITE_LOW;
    else if (r < 75) op = OP_WRITE_HIGH;
    else if (r < 94) op = OP_PIXEL;
    else op = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    if ($urandom_range(0, 31) == 0) begin
      hot_column = 7'($urandom);
      hot_page   = 3'($urandom);
    end
    if ($urandom_range(0, 1) == 0) begin
      col = hot_column + 7'($urandom_range(0, 3));
      pg  = hot_page + 3'($urandom_range(0, 1));
      row = {hot_page, 3'($urandom)} + 6'($urandom_range(0, 7));
    end else begin
      col = 7'($urandom);
      pg  = 3'($urandom);
      row = 6'($urandom);
    end
    // Run lengths are mostly legal; some exceed a page and must saturate.
    if ($urandom_range(0, 9) == 0) count = 4'($urandom_range(9, 15));
    else count = 4'($urandom_range(0, 8));
    send_transaction(op, col, row, pg, 8'($urandom), count);
    if (with_gaps) idle_cycles(pick_gap());
  endtask

  initial begin
    #5_000_000;
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    shadow     = new();
    hot_column = '0;
    hot_page   = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The block clears its store after reset with busy held high, so the
    // first transaction simply waits on the handshake.

    // Whole bytes at the corners of the store.
    issue(OP_WRITE_BYTE, 7'd0,   6'd0, 3'd0, 8'hff, 4'd0);
    issue(OP_WRITE_BYTE, 7'd127, 6'd0, 3'd7, 8'h80, 4'd0);
    issue(OP_READ,       7'd0,   6'd0, 3'd0, 8'h00, 4'd0);
    issue(OP_READ,       7'd127, 6'd0, 3'd7, 8'h00, 4'd0);
    // A full low run at the top of a page clears the byte.
    issue(OP_WRITE_LOW,  7'd0,   6'd0, 3'd0, 8'h00, 4'd8);
    issue(OP_READ,       7'd0,   6'd0, 3'd0, 8'h00, 4'd0);
    // High run that spills into the next page, then a full low run across a
    // boundary further down.
    issue(OP_WRITE_HIGH, 7'd5,   6'd6,  3'd0, 8'hb0, 4'd4);
    issue(OP_WRITE_LOW,  7'd5,   6'd14, 3'd0, 8'ha5, 4'd8);
    issue(OP_READ,       7'd5,   6'd0,  3'd0, 8'h00, 4'd0);
    issue(OP_READ,       7'd5,   6'd0,  3'd1, 8'h00, 4'd0);
    issue(OP_READ,       7'd5,   6'd0,  3'd2, 8'h00, 4'd0);
    // On the last page the spill has nowhere to go and is dropped.
    issue(OP_WRITE_LOW,  7'd127, 6'd60, 3'd0, 8'hff, 4'd8);
    issue(OP_READ,       7'd127, 6'd0,  3'd7, 8'h00, 4'd0);
    // A zero-length run changes nothing; an oversized one acts as eight.
    issue(OP_WRITE_LOW,  7'd9,   6'd3,  3'd0, 8'hff, 4'd0);
    issue(OP_WRITE_HIGH, 7'd9,   6'd0,  3'd0, 8'h5a, 4'd15);
    issue(OP_READ,       7'd9,   6'd0,  3'd0, 8'h00, 4'd0);
    // Pixel set on the bottom row and cleared on the row above, in the last column.
    issue(OP_PIXEL,      7'd127, 6'd63, 3'd0, 8'h01, 4'd0);
    issue(OP_PIXEL,      7'd127, 6'd62, 3'd0, 8'h00, 4'd0);
    issue(OP_READ,       7'd127, 6'd0,  3'd7, 8'h00, 4'd0);
    // Unused operation codes leave the store alone and return nothing.
    issue(OP_UNUSED_LO,  7'd9,   6'd0,  3'd0, 8'h00, 4'd8);
    issue(OP_UNUSED_HI,  7'd9,   6'd0,  3'd0, 8'h00, 4'd8);
    issue(OP_READ,       7'd9,   6'd0,  3'd0, 8'h00, 4'd0);

    // Random traffic: a stretch with gaps, one back to back, and another
    // with gaps.
    repeat (400) random_transaction(1'b1);
    repeat (200) random_transaction(1'b0);
    repeat (550) random_transaction(1'b1);
    start <= 1'b0;

    while (shadow.pending_reads.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (shadow.mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/pfb_pkg.sv
rtl/pfb_front.sv
rtl/pfb_queue.sv
rtl/pfb_back.sv
rtl/page_frame_buffer_writes.sv
test/tb.sv
